>>> src/neighbor_table_aging_macros.svh
// Assertion macros shared by the neighbor table RTL.
`ifndef NEIGHBOR_TABLE_AGING_MACROS_SVH
`define NEIGHBOR_TABLE_AGING_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on clk with reset masking.
`define NTA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on clk with reset masking.
`define NTA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NTA_ASSERT_NOW(label, ante, cons, msg)
`define NTA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> src/nta_pkg.sv
// Types, constants and helpers for the neighbor table with dead timer.
`default_nettype none

package nta_pkg;

    localparam int IFACE_W = 2;
    localparam int WORD_W  = 32;
    localparam int AGE_W   = 16;
    localparam int CNT_W   = 5;

    localparam logic [AGE_W-1:0] AGE_MAX        = '1;
    localparam logic [AGE_W-1:0] DEAD_LIMIT_RST = 16'd15;
    localparam logic [CNT_W-1:0] CNT_MAX        = '1;

    // Command codes carried in the input word.
    localparam logic CMD_HELLO = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [IFACE_W-1:0] iface_index;
        logic [WORD_W-1:0] neighbor_id;
        logic [WORD_W-1:0] neighbor_addr;
        logic [WORD_W-1:0] neighbor_mask;
    } in_word_t;

    typedef struct packed {
        logic             changed;
        logic             refreshed;
        logic             dropped_full;
        logic [CNT_W-1:0] removed_count;
        logic [CNT_W-1:0] iface_count;
    } out_word_t;

    // One stored neighbor; the valid bit lives in flip-flops outside the RAM.
    typedef struct packed {
        logic [IFACE_W-1:0] iface;
        logic [WORD_W-1:0]  id;
        logic [WORD_W-1:0]  addr;
        logic [WORD_W-1:0]  mask;
        logic [AGE_W-1:0]   age;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_WRITE,
        ST_DONE
    } nta_state_t;

    // Counter increment that sticks at its maximum.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

>>> src/neighbor_table_aging.sv
// Top level of the neighbor table with per-entry dead timer.
//
// Usage: the input channel (in_valid / in_ready / in_data) takes one word per
// command. A hello looks up its interface and router id, refreshes a match or
// inserts into the lowest free slot, and flags a full table. A tick ages every
// entry and removes those that reach dead_limit. Every word yields exactly one
// result word on the output channel (out_valid / out_ready / out_data).
// The table lives in a RAM that is walked one entry per cycle by a single
// compare/age unit, which works on the registered RAM read data. A hello on
// an interface at or above IFACES leaves the table alone and skips the walk.
// in_ready is high only while the sequencer is idle, so a new word is taken
// only after the result of the previous one has moved to the output register.
// A result waits in the output register while the receiver stalls; the next
// word may be accepted meanwhile, but its result is held back until the
// previous one is taken. Reset clears all valid bits, so the table is empty at
// once, and sets dead_limit to 15. dead_limit is written through cfg_wr_en /
// cfg_wr_data; the user must write it only while the block is idle, as the
// block itself does not enforce this.
`default_nettype none

`include "neighbor_table_aging_macros.svh"

module neighbor_table_aging
    import nta_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int IFACES  = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [AGE_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_word_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_word_t        out_data
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int ENT_W = $bits(entry_t);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Control and datapath registers.
    nta_state_t       state_reg, state_next;
    in_word_t         job_reg, job_next;
    logic [AGE_W-1:0] dead_limit_reg;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             issue_reg, issue_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             hit_found_reg, hit_found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] removed_reg, removed_next;
    out_word_t        result_reg, result_next;
    out_word_t        out_word_reg, out_word_next;
    logic             out_valid_reg, out_valid_next;

    // RAM port signals.
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    // Shared compare and aging unit operands.
    entry_t           cur_entry;
    entry_t           new_entry;
    logic             cur_valid;
    logic             iface_match;
    logic             id_match;
    logic [AGE_W-1:0] age_inc;
    logic             age_dead;
    logic             in_iface_ok;
    logic             job_iface_ok;

    nta_ram #(
        .WIDTH(ENT_W),
        .DEPTH(ENTRIES)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign cur_entry    = entry_t'(ram_rdata);
    assign cur_valid    = valid_reg[cmp_idx_reg];
    assign iface_match  = (cur_entry.iface == job_reg.iface_index);
    assign id_match     = (cur_entry.id == job_reg.neighbor_id);
    assign age_inc      = (cur_entry.age == AGE_MAX) ? AGE_MAX : cur_entry.age + AGE_W'(1);
    assign age_dead     = (age_inc >= dead_limit_reg);
    assign in_iface_ok  = (int'(in_data.iface_index) < IFACES);
    assign job_iface_ok = (int'(job_reg.iface_index) < IFACES);

    // Fresh entry written by a hello, for both refresh and insert.
    always_comb
    begin
        new_entry       = '0;
        new_entry.iface = job_reg.iface_index;
        new_entry.id    = job_reg.neighbor_id;
        new_entry.addr  = job_reg.neighbor_addr;
        new_entry.mask  = job_reg.neighbor_mask;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_limit_reg <= DEAD_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            dead_limit_reg <= cfg_wr_data;
        end
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            issue_reg     <= 1'b0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and walk bookkeeping registers.
    always_ff @(posedge clk)
    begin
        job_reg        <= job_next;
        rd_idx_reg     <= rd_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        cnt_reg        <= cnt_next;
        removed_reg    <= removed_next;
        result_reg     <= result_next;
        out_word_reg   <= out_word_next;
    end

    // Sequencer: next state, walk control and the shared compare/age unit.
    always_comb
    begin
        state_next      = state_reg;
        job_next        = job_reg;
        valid_next      = valid_reg;
        rd_idx_next     = rd_idx_reg;
        issue_next      = issue_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        cnt_next        = cnt_reg;
        removed_next    = removed_reg;
        result_next     = result_reg;
        out_word_next   = out_word_reg;
        out_valid_next  = out_valid_reg;
        ram_we          = 1'b0;
        ram_waddr       = cmp_idx_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = rd_idx_reg;

        // The receiver takes the waiting result word.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    job_next        = in_data;
                    rd_idx_next     = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    cnt_next        = '0;
                    removed_next    = '0;
                    if (in_data.cmd == CMD_HELLO && !in_iface_ok)
                    begin
                        // A hello on an unknown interface leaves the table alone.
                        result_next = '0;
                        issue_next  = 1'b0;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        issue_next = 1'b1;
                        state_next = ST_WALK;
                    end
                end
            end

            ST_WALK:
            begin
                // Issue the next RAM read.
                if (issue_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_idx_reg;
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                    end
                end

                // Examine the entry whose data has just arrived.
                if (cmp_valid_reg)
                begin
                    if (job_reg.cmd == CMD_HELLO)
                    begin
                        if (cur_valid && iface_match)
                        begin
                            cnt_next = sat_inc(cnt_reg);
                            if (id_match && !hit_found_reg)
                            begin
                                hit_found_next = 1'b1;
                                hit_idx_next   = cmp_idx_reg;
                            end
                        end
                        if (!cur_valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = cmp_idx_reg;
                        end
                    end
                    else if (cur_valid)
                    begin
                        if (age_dead)
                        begin
                            valid_next[cmp_idx_reg] = 1'b0;
                            removed_next            = sat_inc(removed_reg);
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = {cur_entry.iface, cur_entry.id, cur_entry.addr,
                                         cur_entry.mask, age_inc};
                            if (iface_match && job_iface_ok)
                            begin
                                cnt_next = sat_inc(cnt_reg);
                            end
                        end
                    end

                    if (cmp_idx_reg == LAST_IDX)
                    begin
                        if (job_reg.cmd == CMD_HELLO)
                        begin
                            state_next = ST_WRITE;
                        end
                        else
                        begin
                            result_next.changed       = (removed_next != '0);
                            result_next.refreshed     = 1'b0;
                            result_next.dropped_full  = 1'b0;
                            result_next.removed_count = removed_next;
                            result_next.iface_count   = cnt_next;
                            state_next                = ST_DONE;
                        end
                    end
                end
            end

            ST_WRITE:
            begin
                // Refresh a match, else insert into the first free slot, else flag a full table.
                result_next               = '0;
                result_next.iface_count   = cnt_reg;
                ram_wdata                 = new_entry;
                if (hit_found_reg)
                begin
                    ram_we                = 1'b1;
                    ram_waddr             = hit_idx_reg;
                    result_next.refreshed = 1'b1;
                end
                else if (free_found_reg)
                begin
                    ram_we                    = 1'b1;
                    ram_waddr                 = free_idx_reg;
                    valid_next[free_idx_reg]  = 1'b1;
                    result_next.changed       = 1'b1;
                    result_next.iface_count   = sat_inc(cnt_reg);
                end
                else
                begin
                    result_next.dropped_full = 1'b1;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                // Hand the result to the output register once it is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = result_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Consistency checks on the result and the sequencer.
    `NTA_ASSERT_NOW(a_flags_exclusive, out_valid_reg,
        $onehot0({out_word_reg.changed, out_word_reg.refreshed, out_word_reg.dropped_full}),
        "result flags are not mutually exclusive")
    `NTA_ASSERT_NOW(a_removed_changes, out_valid_reg && out_word_reg.removed_count != '0,
        out_word_reg.changed, "removals reported without a change")
    `NTA_ASSERT_NOW(a_refresh_counted, out_valid_reg && out_word_reg.refreshed,
        out_word_reg.iface_count != '0, "refreshed neighbor missing from interface count")
    `NTA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
        "sequencer ready again right after accepting a word")

endmodule

`default_nettype wire

>>> src/nta_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module nta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> verif/tb_neighbor_table_aging.sv
// Self-checking testbench for the neighbor table with per-entry dead timer.
`timescale 1ns / 100ps

module tb_neighbor_table_aging
    import nta_pkg::*;
();

    localparam int NUM_ENTRIES = 16;
    localparam int NUM_IFACES  = 4;
    localparam int LATENCY     = NUM_ENTRIES + 3;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int ID_POOL     = 20;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [AGE_W-1:0] cfg_wr_data = '0;
    logic             in_valid    = 1'b0;
    logic             in_ready;
    in_word_t         in_data     = '0;
    logic             out_valid;
    logic             out_ready   = 1'b0;
    out_word_t        out_data;

    // Words waiting to be sent and results waiting to be seen.
    in_word_t  pending_words[$];
    out_word_t expected_results[$];

    int items_queued    = 0;
    int results_checked = 0;
    int error_count     = 0;
    int gap_left        = 0;
    int stall_left      = 0;
    int hold_left       = 0;
    int idle_cycles     = 0;
    bit hold_done       = 1'b0;
    bit calm            = 1'b0;

    logic [WORD_W-1:0] id_pool [ID_POOL];

    // Shadow copy of the neighbor table and the dead limit.
    logic               nbr_valid [NUM_ENTRIES];
    logic [IFACE_W-1:0] nbr_iface [NUM_ENTRIES];
    logic [WORD_W-1:0]  nbr_id    [NUM_ENTRIES];
    logic [AGE_W-1:0]   nbr_age   [NUM_ENTRIES];
    int unsigned        nbr_count [NUM_IFACES];
    logic [AGE_W-1:0]   limit_model;

    neighbor_table_aging #(
        .ENTRIES (NUM_ENTRIES),
        .IFACES  (NUM_IFACES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [CNT_W-1:0] sat_count(input int unsigned v);
        return (v > 31) ? CNT_W'(31) : CNT_W'(v);
    endfunction

    // Applies one word to the shadow table and returns the result it should give.
    function automatic out_word_t predict_neighbor_result(input in_word_t w);
        out_word_t   res;
        int          hit;
        int          free_slot;
        int unsigned removed;
        res       = '0;
        hit       = -1;
        free_slot = -1;
        removed   = 0;
        if (w.cmd == CMD_HELLO)
        begin
            if (int'(w.iface_index) < NUM_IFACES)
            begin
                for (int i = 0; i < NUM_ENTRIES; i++)
                begin
                    if (nbr_valid[i])
                    begin
                        if (hit < 0 && nbr_iface[i] == w.iface_index &&
                            nbr_id[i] == w.neighbor_id)
                            hit = i;
                    end
                    else if (free_slot < 0)
                    begin
                        free_slot = i;
                    end
                end
                if (hit >= 0)
                begin
                    nbr_age[hit]  = '0;
                    res.refreshed = 1'b1;
                end
                else if (free_slot >= 0)
                begin
                    nbr_valid[free_slot] = 1'b1;
                    nbr_iface[free_slot] = w.iface_index;
                    nbr_id[free_slot]    = w.neighbor_id;
                    nbr_age[free_slot]   = '0;
                    nbr_count[w.iface_index]++;
                    res.changed = 1'b1;
                end
                else
                begin
                    res.dropped_full = 1'b1;
                end
                res.iface_count = sat_count(nbr_count[w.iface_index]);
            end
        end
        else
        begin
            // Age every live entry; ages stick at the top of their range.
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                if (nbr_valid[i])
                begin
                    if (nbr_age[i] != AGE_MAX)
                        nbr_age[i] = nbr_age[i] + 1'b1;
                    if (nbr_age[i] >= limit_model)
                    begin
                        nbr_valid[i] = 1'b0;
                        if (nbr_count[nbr_iface[i]] > 0)
                            nbr_count[nbr_iface[i]]--;
                        removed++;
                    end
                end
            end
            res.changed       = (removed != 0);
            res.removed_count = sat_count(removed);
            if (int'(w.iface_index) < NUM_IFACES)
                res.iface_count = sat_count(nbr_count[w.iface_index]);
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input out_word_t want,
                                 input out_word_t got);
        string want_s;
        string got_s;
        want_s = $sformatf("chg=%0d ref=%0d drop=%0d rem=%0d cnt=%0d",
                           want.changed, want.refreshed, want.dropped_full,
                           want.removed_count, want.iface_count);
        got_s  = $sformatf("chg=%0d ref=%0d drop=%0d rem=%0d cnt=%0d",
                           got.changed, got.refreshed, got.dropped_full,
                           got.removed_count, got.iface_count);
        if (error_count < 10)
            $display("%0t %s: expected %s, got %s", $time, what, want_s, got_s);
        error_count++;
    endtask

    task automatic queue_word(input logic cmd, input logic [IFACE_W-1:0] ifc,
                              input logic [WORD_W-1:0] id, input logic [WORD_W-1:0] addr,
                              input logic [WORD_W-1:0] mask);
        in_word_t w;
        w.cmd           = cmd;
        w.iface_index   = ifc;
        w.neighbor_id   = id;
        w.neighbor_addr = addr;
        w.neighbor_mask = mask;
        pending_words.push_back(w);
        items_queued++;
    endtask

    // The limit is changed only once every result is in and the block has settled.
    task automatic write_dead_limit(input logic [AGE_W-1:0] value);
        while (results_checked != items_queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        limit_model = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly hellos from a small set of router ids so that entries get refreshed,
    // the table fills up and neighbors age out; a few hellos carry fresh ids.
    task automatic run_random_phase(input int count, input int tick_pct);
        int pick;
        for (int i = 0; i < ID_POOL; i++)
            id_pool[i] = $urandom;
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < tick_pct)
                queue_word(CMD_TICK, IFACE_W'($urandom_range(0, 3)), $urandom, $urandom,
                           $urandom);
            else if (pick < 94)
                queue_word(CMD_HELLO, IFACE_W'($urandom_range(0, 3)),
                           id_pool[$urandom_range(0, ID_POOL - 1)], $urandom, $urandom);
            else
                queue_word(CMD_HELLO, IFACE_W'($urandom_range(0, 3)), $urandom, $urandom,
                           $urandom);
        end
    endtask

    // Main sequence: reset, directed words, then random phases over several limits.
    initial
    begin
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            nbr_valid[i] = 1'b0;
            nbr_iface[i] = '0;
            nbr_id[i]    = '0;
            nbr_age[i]   = '0;
        end
        for (int i = 0; i < NUM_IFACES; i++)
            nbr_count[i] = 0;
        limit_model = DEAD_LIMIT_RST;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // New neighbors at the field extremes, a refresh, the same id elsewhere.
        queue_word(CMD_HELLO, 2'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        queue_word(CMD_HELLO, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_word(CMD_HELLO, 2'd0, 32'h0000_0000, 32'hC0A8_0001, 32'hFFFF_FF00);
        queue_word(CMD_HELLO, 2'd1, 32'h0000_0000, 32'h0A00_0001, 32'hFF00_0000);
        queue_word(CMD_TICK, 2'd2, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678);
        // Fill the table, overflow it, then refresh while it is full.
        for (int unsigned i = 1; i <= 13; i++)
            queue_word(CMD_HELLO, 2'd2, i, $urandom, $urandom);
        queue_word(CMD_HELLO, 2'd2, 32'h0000_0064, 32'h0101_0101, 32'hFFFF_0000);
        queue_word(CMD_HELLO, 2'd3, 32'hFFFF_FFFF, 32'h0202_0202, 32'hFFFF_FFFC);

        // A limit of one empties the full table on a single tick.
        write_dead_limit(16'd1);
        queue_word(CMD_TICK, 2'd2, 32'h0, 32'h0, 32'h0);
        queue_word(CMD_HELLO, 2'd1, 32'h8000_0001, 32'h0, 32'h0);
        queue_word(CMD_TICK, 2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // A zero limit removes every live entry on the next tick.
        write_dead_limit(16'd0);
        queue_word(CMD_HELLO, 2'd2, 32'h0000_0007, 32'h0, 32'h0);
        queue_word(CMD_HELLO, 2'd2, 32'h0000_0007, 32'h1, 32'h1);
        queue_word(CMD_TICK, 2'd2, 32'h0, 32'h0, 32'h0);

        write_dead_limit(16'hFFFF);
        queue_word(CMD_HELLO, 2'd0, 32'h0000_0009, 32'h0, 32'h0);
        queue_word(CMD_TICK, 2'd0, 32'h0, 32'h0, 32'h0);

        run_random_phase(120, 10);
        write_dead_limit(16'd3);
        run_random_phase(130, 30);
        write_dead_limit(16'd1);
        run_random_phase(100, 40);
        write_dead_limit(16'd0);
        run_random_phase(80, 30);
        write_dead_limit(AGE_W'($urandom_range(2, 40)));
        run_random_phase(140, 20);
        write_dead_limit(DEAD_LIMIT_RST);
        calm = 1'b1;
        run_random_phase(180, 15);

        while (results_checked != items_queued)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
        while (expected_results.size() != 0)
            flag_mismatch("missing result", expected_results.pop_front(), '0);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Sender: predicts each accepted word and offers the next one, with random gaps.
    always @(posedge clk)
    begin : drive_words
        logic taken;
        if (rst_n)
        begin
            taken = in_valid && in_ready;
            if (taken)
                expected_results.push_back(predict_neighbor_result(in_data));
            if (!in_valid || taken)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0 && !calm &&
                         $urandom_range(0, 7) == 0)
                begin
                    gap_left <= $urandom_range(0, 17);
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    in_data  <= pending_words.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted result against the oldest prediction.
    always @(posedge clk)
    begin : check_results
        out_word_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_checked <= results_checked + 1;
                if (expected_results.size() == 0)
                begin
                    flag_mismatch("unexpected result", '0, out_data);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.changed !== want.changed ||
                        out_data.refreshed !== want.refreshed ||
                        out_data.dropped_full !== want.dropped_full ||
                        out_data.removed_count !== want.removed_count ||
                        out_data.iface_count !== want.iface_count)
                        flag_mismatch("result mismatch", want, out_data);
                end
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall_left <= $urandom_range(0, 17);
                out_ready  <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // One long receiver hold-off early on, so the block backs up and stalls its input.
    always @(posedge clk)
    begin : receiver_holdoff
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && results_checked >= 60)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Watchdog: ends the run if no word moves on either channel for too long.
    always @(posedge clk)
    begin : watchdog
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
